// ===== sv/barometric_sensor_compensation_top_defines.svh =====
// Assertion macros for the barometric compensation block.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`ifndef SYNTH
`define BSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSC_ASSERT_IMP(lbl, ante, cons)
`define BSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/bsc_pkg.sv =====
// Types, constants and helpers of the barometric compensation block.
// No dependencies.
`default_nettype none
package bsc_pkg;
    localparam int MUL_LANES = 3;
    localparam int DIV_BITS  = 64;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_FULL  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;
    localparam logic [63:0] P1_BIAS     = 64'h0000_8000_0000_0000;
    localparam int          P4_SHIFT    = 35;

    typedef enum logic [1:0] {
        REG_TEMP    = 2'd0,
        REG_PRESS_A = 2'd1,
        REG_PRESS_B = 2'd2,
        REG_PRESS_C = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] adc_temperature;
        logic [19:0] adc_pressure;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } t_out;

    typedef struct packed {
        logic        vld;
        logic [31:0] temp;
        logic [31:0] fine;
        logic        zero;
        logic [63:0] aux0;
        logic [63:0] aux1;
    } t_ctx;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

// ===== sv/bsc_mul64.sv =====
// Three-lane 64x64 multiplier, low 64 bits, two register stages.
// Carries a bsc_pkg::t_ctx alongside; depends on bsc_pkg.
`default_nettype none
module bsc_mul64 (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic [bsc_pkg::MUL_LANES-1:0][63:0]   i_a,
    input  wire logic [bsc_pkg::MUL_LANES-1:0][63:0]   i_b,
    input  wire bsc_pkg::t_ctx                         i_ctx,
    output logic      [bsc_pkg::MUL_LANES-1:0][63:0]   o_p,
    output bsc_pkg::t_ctx                              o_ctx
);
    logic [bsc_pkg::MUL_LANES-1:0][63:0] r_ll;
    logic [bsc_pkg::MUL_LANES-1:0][31:0] r_lh;
    logic [bsc_pkg::MUL_LANES-1:0][31:0] r_hl;
    logic [bsc_pkg::MUL_LANES-1:0][63:0] r_p;
    bsc_pkg::t_ctx r_ctx_a;
    bsc_pkg::t_ctx r_ctx_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_a.vld <= 1'b0;
            r_ctx_b.vld <= 1'b0;
        end else if (i_en) begin
            r_ctx_a <= i_ctx;
            r_ctx_b <= r_ctx_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < bsc_pkg::MUL_LANES; l++) begin
                r_ll[l] <= 64'(i_a[l][31:0]) * 64'(i_b[l][31:0]);
                r_lh[l] <= i_a[l][31:0] * i_b[l][63:32];
                r_hl[l] <= i_a[l][63:32] * i_b[l][31:0];
                r_p[l]  <= r_ll[l] + {r_lh[l] + r_hl[l], 32'b0};
            end
        end
    end

    assign o_p   = r_p;
    assign o_ctx = r_ctx_b;
endmodule
`default_nettype wire

// ===== sv/bsc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Divisor magnitude below 2^31; depends on bsc_pkg.
`default_nettype none
module bsc_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [63:0]   i_num,
    input  wire logic [63:0]   i_den,
    input  wire bsc_pkg::t_ctx i_ctx,
    output logic [63:0]        o_q,
    output bsc_pkg::t_ctx      o_ctx
);
    localparam int N = bsc_pkg::DIV_BITS;

    logic [31:0]   r_rem [N+1];
    logic [63:0]   r_dq  [N+1];
    logic [31:0]   r_md  [N+1];
    logic          r_neg [N+1];
    bsc_pkg::t_ctx r_ctx [N+1];
    logic [63:0]   r_q;
    bsc_pkg::t_ctx r_ctx_q;
    logic [63:0]   neg_den;

    assign neg_den = 64'd0 - i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx[0].vld <= 1'b0;
        end else if (i_en) begin
            r_ctx[0] <= i_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 32'd0;
            r_dq[0]  <= i_num[63] ? 64'd0 - i_num : i_num;
            r_md[0]  <= i_den[63] ? neg_den[31:0] : i_den[31:0];
            r_neg[0] <= i_num[63] ^ i_den[63];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [32:0] rem_sh;
        logic [32:0] diff;
        logic        ge;

        assign rem_sh = {r_rem[g], r_dq[g][63]};
        assign diff   = rem_sh - {1'b0, r_md[g]};
        assign ge     = !diff[32];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctx[g+1].vld <= 1'b0;
            end else if (i_en) begin
                r_ctx[g+1] <= r_ctx[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= ge ? diff[31:0] : rem_sh[31:0];
                r_dq[g+1]  <= {r_dq[g][62:0], ge};
                r_md[g+1]  <= r_md[g];
                r_neg[g+1] <= r_neg[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_q.vld <= 1'b0;
        end else if (i_en) begin
            r_ctx_q <= r_ctx[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[N] ? 64'd0 - r_dq[N] : r_dq[N];
        end
    end

    assign o_q   = r_q;
    assign o_ctx = r_ctx_q;
endmodule
`default_nettype wire

// ===== sv/barometric_sensor_compensation_top.sv =====
// Barometric sensor integer compensation, fully pipelined.
// Pipeline depth is dominated by the 64-stage divider.
// Throughput: one pair per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous active low; clears stage valid bits and the four coefficient registers.
// Depends on bsc_pkg, bsc_mul64, bsc_div and the defines header.
`default_nettype none
`include "barometric_sensor_compensation_top_defines.svh"
module barometric_sensor_compensation_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire bsc_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output bsc_pkg::t_out     o_out_data,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [47:0]  i_cfg_wdata
);
    logic [47:0] r_cfg_t, r_cfg_a, r_cfg_b, r_cfg_c;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t <= 48'd0;
            r_cfg_a <= 48'd0;
            r_cfg_b <= 48'd0;
            r_cfg_c <= 48'd0;
        end else if (i_cfg_we) begin
            case (bsc_pkg::t_reg_idx'(i_cfg_idx))
                bsc_pkg::REG_TEMP:    r_cfg_t <= i_cfg_wdata;
                bsc_pkg::REG_PRESS_A: r_cfg_a <= i_cfg_wdata;
                bsc_pkg::REG_PRESS_B: r_cfg_b <= i_cfg_wdata;
                bsc_pkg::REG_PRESS_C: r_cfg_c <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, r_cfg_t[15:0]};
    assign t2 = 32'(bsc_pkg::sx16(r_cfg_t[31:16]));
    assign t3 = 32'(bsc_pkg::sx16(r_cfg_t[47:32]));
    assign p1 = {48'd0, r_cfg_a[15:0]};
    assign p2 = bsc_pkg::sx16(r_cfg_a[31:16]);
    assign p3 = bsc_pkg::sx16(r_cfg_a[47:32]);
    assign p4 = bsc_pkg::sx16(r_cfg_b[15:0]);
    assign p5 = bsc_pkg::sx16(r_cfg_b[31:16]);
    assign p6 = bsc_pkg::sx16(r_cfg_b[47:32]);
    assign p7 = bsc_pkg::sx16(r_cfg_c[15:0]);
    assign p8 = bsc_pkg::sx16(r_cfg_c[31:16]);
    assign p9 = bsc_pkg::sx16(r_cfg_c[47:32]);

    logic r_out_vld;
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;

    // temperature stages
    logic        r_s1_vld, r_s2_vld, r_s3_vld;
    logic [31:0] r_s1_pa, r_s1_dd, r_s2_v1, r_s2_sqt3, r_s3_fine;
    logic [19:0] r_s1_adcp, r_s2_adcp, r_s3_adcp;
    logic [31:0] n_a, n_d, n_sq, n_fine5;
    bsc_pkg::t_ctx r_s4;

    assign n_a     = {15'd0, i_in_data.adc_temperature[19:3]} - {t1[30:0], 1'b0};
    assign n_d     = {16'd0, i_in_data.adc_temperature[19:4]} - t1;
    assign n_sq    = 32'($signed(r_s1_dd) >>> 12);
    assign n_fine5 = r_s3_fine * 32'd5 + bsc_pkg::TEMP_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pa   <= n_a * t2;
            r_s1_dd   <= n_d * n_d;
            r_s1_adcp <= i_in_data.adc_pressure;
            r_s2_v1   <= 32'($signed(r_s1_pa) >>> 11);
            r_s2_sqt3 <= n_sq * t3;
            r_s2_adcp <= r_s1_adcp;
            r_s3_fine <= r_s2_v1 + 32'($signed(r_s2_sqt3) >>> 14);
            r_s3_adcp <= r_s2_adcp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else if (en) begin
            r_s4.vld  <= r_s3_vld;
            r_s4.temp <= 32'($signed(n_fine5) >>> 8);
            r_s4.fine <= r_s3_fine;
            r_s4.zero <= 1'b0;
            r_s4.aux0 <= {{32{r_s3_fine[31]}}, r_s3_fine} - bsc_pkg::FINE_OFFSET;
            r_s4.aux1 <= bsc_pkg::PRESS_FULL - {44'd0, r_s3_adcp};
        end
    end

    // x1*x1, x1*P5, x1*P2
    logic [bsc_pkg::MUL_LANES-1:0][63:0] m1_a, m1_b, m1_p;
    bsc_pkg::t_ctx m1_ctx;
    assign m1_a = {r_s4.aux0, r_s4.aux0, r_s4.aux0};
    assign m1_b = {p2, p5, r_s4.aux0};

    bsc_mul64 u_mul1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(m1_a), .i_b(m1_b), .i_ctx(r_s4), .o_p(m1_p), .o_ctx(m1_ctx)
    );

    // x1^2*P6, x1^2*P3; carry (p<<31) - x1*P5<<17 - P4<<35 and P2 term + bias
    logic [bsc_pkg::MUL_LANES-1:0][63:0] m2_a, m2_b, m2_p;
    bsc_pkg::t_ctx m2_in, m2_ctx;
    always_comb begin
        m2_in      = m1_ctx;
        m2_in.aux0 = (m1_ctx.aux1 << 31) - ((m1_p[1] << 17) + (p4 << bsc_pkg::P4_SHIFT));
        m2_in.aux1 = (m1_p[2] << 12) + bsc_pkg::P1_BIAS;
    end
    assign m2_a = {64'd0, m1_p[0], m1_p[0]};
    assign m2_b = {64'd0, p3, p6};

    bsc_mul64 u_mul2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(m2_a), .i_b(m2_b), .i_ctx(m2_in), .o_p(m2_p), .o_ctx(m2_ctx)
    );

    bsc_pkg::t_ctx r_s9;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9.vld <= 1'b0;
        end else if (en) begin
            r_s9.vld  <= m2_ctx.vld;
            r_s9.temp <= m2_ctx.temp;
            r_s9.fine <= m2_ctx.fine;
            r_s9.zero <= m2_ctx.zero;
            r_s9.aux0 <= m2_ctx.aux0 - m2_p[0];
            r_s9.aux1 <= 64'($signed(m2_p[1]) >>> 8) + m2_ctx.aux1;
        end
    end

    // divisor product and numerator product
    logic [bsc_pkg::MUL_LANES-1:0][63:0] m3_a, m3_b, m3_p;
    bsc_pkg::t_ctx m3_ctx;
    assign m3_a = {64'd0, r_s9.aux0, r_s9.aux1};
    assign m3_b = {64'd0, bsc_pkg::PRESS_SCALE, p1};

    bsc_mul64 u_mul3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(m3_a), .i_b(m3_b), .i_ctx(r_s9), .o_p(m3_p), .o_ctx(m3_ctx)
    );

    bsc_pkg::t_ctx r_s12;
    logic [63:0]   n_den;
    assign n_den = 64'($signed(m3_p[0]) >>> 33);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12.vld <= 1'b0;
        end else if (en) begin
            r_s12.vld  <= m3_ctx.vld;
            r_s12.temp <= m3_ctx.temp;
            r_s12.fine <= m3_ctx.fine;
            r_s12.zero <= (n_den == 64'd0);
            r_s12.aux0 <= m3_p[1];
            r_s12.aux1 <= n_den;
        end
    end

    logic [63:0]   q;
    bsc_pkg::t_ctx d_ctx;

    bsc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_num(r_s12.aux0), .i_den(r_s12.aux1), .i_ctx(r_s12),
        .o_q(q), .o_ctx(d_ctx)
    );

    // (p>>13)^2 and P8*p
    logic [bsc_pkg::MUL_LANES-1:0][63:0] m4_a, m4_b, m4_p;
    bsc_pkg::t_ctx m4_in, m4_ctx;
    logic [63:0]   ps;
    assign ps = 64'($signed(q) >>> 13);
    always_comb begin
        m4_in      = d_ctx;
        m4_in.aux0 = q;
    end
    assign m4_a = {64'd0, p8, ps};
    assign m4_b = {64'd0, q, ps};

    bsc_mul64 u_mul4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(m4_a), .i_b(m4_b), .i_ctx(m4_in), .o_p(m4_p), .o_ctx(m4_ctx)
    );

    // P9 * ps^2
    logic [bsc_pkg::MUL_LANES-1:0][63:0] m5_a, m5_b, m5_p;
    bsc_pkg::t_ctx m5_in, m5_ctx;
    always_comb begin
        m5_in      = m4_ctx;
        m5_in.aux1 = 64'($signed(m4_p[1]) >>> 19);
    end
    assign m5_a = {64'd0, 64'd0, m4_p[0]};
    assign m5_b = {64'd0, 64'd0, p9};

    bsc_mul64 u_mul5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_a(m5_a), .i_b(m5_b), .i_ctx(m5_in), .o_p(m5_p), .o_ctx(m5_ctx)
    );

    logic [63:0]   n_sum, n_res;
    bsc_pkg::t_out r_out;
    assign n_sum = m5_ctx.aux0 + 64'($signed(m5_p[0]) >>> 25) + m5_ctx.aux1;
    assign n_res = 64'($signed(n_sum) >>> 8) + (p7 << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= m5_ctx.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.temperature_centi <= m5_ctx.temp;
            r_out.fine_temperature  <= m5_ctx.fine;
            r_out.pressure_q24_8    <= m5_ctx.zero ? 32'd0 : n_res[31:0];
            r_out.pressure_valid    <= !m5_ctx.zero;
        end
    end

    assign o_out_data = r_out;

    `BSC_ASSERT_IMP(a_zero_press, o_out_valid && !o_out_data.pressure_valid, o_out_data.pressure_q24_8 == 32'd0)
    `BSC_ASSERT_NXT(a_stall_hold, !en, $stable(r_s4.vld) && $stable(r_s12.vld))
    `BSC_ASSERT_NXT(a_front_flow, en && i_in_valid, r_s1_vld)
endmodule
`default_nettype wire

// ===== tb/sv/barometric_sensor_compensation_top_test.sv =====
// Testbench for barometric_sensor_compensation_top: directed table, then random sensor pairs.
// Expected results come from an in-bench integer compensation predictor; depends on bsc_pkg.
`timescale 1ns / 100ps
module barometric_sensor_compensation_top_test;
    localparam int LATENCY = 83;
    localparam int N_RANDOM = 1700;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    bsc_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    bsc_pkg::t_out  o_out_data;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_idx;
    logic [47:0]    i_cfg_wdata;

    logic [47:0]    coeff_regs [4];
    bsc_pkg::t_out  pending_results [$];
    bit             failed;
    bit             stim_done;

    typedef struct {
        bit            has_expect;
        logic [19:0]   adc_t;
        logic [19:0]   adc_p;
        bsc_pkg::t_out result;
    } t_row;

    barometric_sensor_compensation_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic signed [63:0] coeff_s(input logic [47:0] r, input int k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return {{48{w[15]}}, w};
    endfunction

    function automatic bsc_pkg::t_out compensate(input logic [19:0] adc_t,
                                                 input logic [19:0] adc_p);
        logic signed [31:0] t1, t2, t3, a, v1, d, sq, v2, fine, temp;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] x1, x2, y, dv, num, q, ps, z1, z2, p;
        logic [63:0] mn, md, mq;
        bsc_pkg::t_out r;
        t1 = {16'd0, coeff_regs[bsc_pkg::REG_TEMP][15:0]};
        t2 = 32'(coeff_s(coeff_regs[bsc_pkg::REG_TEMP], 1));
        t3 = 32'(coeff_s(coeff_regs[bsc_pkg::REG_TEMP], 2));
        a = 32'({12'd0, adc_t} >> 3) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        d = 32'({12'd0, adc_t} >> 4) - t1;
        sq = (d * d) >>> 12;
        v2 = (sq * t3) >>> 14;
        fine = v1 + v2;
        temp = (fine * 32'sd5 + 32'sd128) >>> 8;
        p1 = {48'd0, coeff_regs[bsc_pkg::REG_PRESS_A][15:0]};
        p2 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_A], 1);
        p3 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_A], 2);
        p4 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_B], 0);
        p5 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_B], 1);
        p6 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_B], 2);
        p7 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_C], 0);
        p8 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_C], 1);
        p9 = coeff_s(coeff_regs[bsc_pkg::REG_PRESS_C], 2);
        x1 = 64'(fine) - 64'sd128000;
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) <<< 17);
        x2 = x2 + (p4 <<< 35);
        y = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
        dv = ((64'sd1 <<< 47) + y) * p1 >>> 33;
        r.temperature_centi = temp;
        r.fine_temperature = fine;
        r.pressure_q24_8 = '0;
        r.pressure_valid = 1'b0;
        if (dv != 0) begin
            p = 64'sd1048576 - 64'($unsigned(adc_p));
            num = ((p <<< 31) - x2) * 64'sd3125;
            mn = num[63] ? -num : num;
            md = dv[63] ? -dv : dv;
            mq = mn / md;
            q = (num[63] != dv[63]) ? -mq : mq;
            ps = q >>> 13;
            z1 = (p9 * ps * ps) >>> 25;
            z2 = (p8 * q) >>> 19;
            p = ((q + z1 + z2) >>> 8) + (p7 <<< 4);
            r.pressure_q24_8 = p[31:0];
            r.pressure_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic write_coeff(input bsc_pkg::t_reg_idx idx, input logic [47:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        coeff_regs[idx] = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p);
        int idle;
        idle = $urandom_range(0, 18);
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{adc_temperature: adc_t, adc_pressure: adc_p};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(compensate(adc_t, adc_p));
        @(negedge i_clk);
    endtask

    // Bursts with no gaps keep the pipeline full on some phases.
    task automatic send_burst(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            i_in_valid <= 1'b1;
            i_in_data <= '{adc_temperature: 20'($urandom), adc_pressure: 20'($urandom)};
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            pending_results.push_back(compensate(i_in_data.adc_temperature,
                                                 i_in_data.adc_pressure));
            @(negedge i_clk);
        end
    endtask

    function automatic logic [47:0] typical_temp();
        return {16'($urandom_range(0, 100)), 16'(26000 + $urandom_range(0, 1000)),
                16'(27000 + $urandom_range(0, 2000))};
    endfunction

    always @(posedge i_clk) begin
        bsc_pkg::t_out expected;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                failed = 1'b1;
            end else begin
                expected = pending_results.pop_front();
                if (o_out_data.temperature_centi !== expected.temperature_centi) begin
                    $display("%0t: temperature_centi expected %0d actual %0d", $time,
                             expected.temperature_centi, o_out_data.temperature_centi);
                    failed = 1'b1;
                end
                if (o_out_data.fine_temperature !== expected.fine_temperature) begin
                    $display("%0t: fine_temperature expected %0d actual %0d", $time,
                             expected.fine_temperature, o_out_data.fine_temperature);
                    failed = 1'b1;
                end
                if (o_out_data.pressure_q24_8 !== expected.pressure_q24_8) begin
                    $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                             expected.pressure_q24_8, o_out_data.pressure_q24_8);
                    failed = 1'b1;
                end
                if (o_out_data.pressure_valid !== expected.pressure_valid) begin
                    $display("%0t: pressure_valid expected %b actual %b", $time,
                             expected.pressure_valid, o_out_data.pressure_valid);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && !stim_done) stall = ($urandom_range(0, 3) == 0) ? 0 :
                                                        $urandom_range(0, 18);
                else stall = 0;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row row;
        bsc_pkg::t_out got;
        logic [47:0] tt;
        int i;
        failed = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bsc_pkg::REG_TEMP;
        i_cfg_wdata = '0;
        for (i = 0; i < 4; i++) coeff_regs[i] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // After reset all coefficients are zero: divisor zero, pressure invalid.
        rows.push_back('{1, 20'd0, 20'd0, '{0, 0, 0, 0}});
        rows.push_back('{1, 20'hFFFFF, 20'hFFFFF, '{0, 0, 0, 0}});
        rows.push_back('{1, 20'hFFFFF, 20'd0, '{0, 0, 0, 0}});
        foreach (rows[j]) begin
            row = rows[j];
            got = compensate(row.adc_t, row.adc_p);
            if (row.has_expect && got !== row.result) begin
                $display("%0t: zero coefficient row %0d expected %h actual %h", $time, j,
                         row.result, got);
                failed = 1'b1;
            end
            send_pair(row.adc_t, row.adc_p);
        end
        drain();

        // Typical calibration, then extremes of every coefficient word.
        write_coeff(bsc_pkg::REG_TEMP, {16'd50, 16'd26435, 16'd27504});
        write_coeff(bsc_pkg::REG_PRESS_A, {16'hF70E, 16'hD5D0, 16'd36477});
        write_coeff(bsc_pkg::REG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
        write_coeff(bsc_pkg::REG_PRESS_C, {16'd6000, 16'hD7F8, 16'd15500});
        rows.delete();
        rows.push_back('{0, 20'd519888, 20'd415148, '{0, 0, 0, 0}});
        rows.push_back('{0, 20'd0, 20'd0, '{0, 0, 0, 0}});
        rows.push_back('{0, 20'hFFFFF, 20'hFFFFF, '{0, 0, 0, 0}});
        rows.push_back('{0, 20'h55555, 20'hAAAAA, '{0, 0, 0, 0}});
        rows.push_back('{0, 20'hAAAAA, 20'h55555, '{0, 0, 0, 0}});
        foreach (rows[j]) send_pair(rows[j].adc_t, rows[j].adc_p);
        drain();
        write_coeff(bsc_pkg::REG_TEMP, 48'hFFFF_FFFF_FFFF);
        write_coeff(bsc_pkg::REG_PRESS_A, 48'hFFFF_FFFF_FFFF);
        write_coeff(bsc_pkg::REG_PRESS_B, 48'hFFFF_FFFF_FFFF);
        write_coeff(bsc_pkg::REG_PRESS_C, 48'hFFFF_FFFF_FFFF);
        foreach (rows[j]) send_pair(rows[j].adc_t, rows[j].adc_p);
        drain();
        write_coeff(bsc_pkg::REG_TEMP, 48'h8000_8000_FFFF);
        write_coeff(bsc_pkg::REG_PRESS_A, 48'h7FFF_7FFF_0001);
        write_coeff(bsc_pkg::REG_PRESS_B, 48'h8000_7FFF_8000);
        write_coeff(bsc_pkg::REG_PRESS_C, 48'h7FFF_8000_7FFF);
        foreach (rows[j]) send_pair(rows[j].adc_t, rows[j].adc_p);
        drain();

        // Random phases: mostly typical calibrations, some fully random, some P1 zero.
        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                drain();
                case ($urandom_range(0, 4))
                    0: begin
                        write_coeff(bsc_pkg::REG_TEMP,
                                    48'($urandom) | (48'($urandom) << 32));
                        write_coeff(bsc_pkg::REG_PRESS_A,
                                    48'($urandom) | (48'($urandom) << 32));
                        write_coeff(bsc_pkg::REG_PRESS_B,
                                    48'($urandom) | (48'($urandom) << 32));
                        write_coeff(bsc_pkg::REG_PRESS_C,
                                    48'($urandom) | (48'($urandom) << 32));
                    end
                    1: write_coeff(bsc_pkg::REG_PRESS_A, {32'($urandom), 16'd0});
                    default: begin
                        tt = typical_temp();
                        write_coeff(bsc_pkg::REG_TEMP, {tt[47:16], 16'(26000 +
                                    $urandom_range(0, 3000))});
                        write_coeff(bsc_pkg::REG_PRESS_A, {16'(-$urandom_range(0, 3000)),
                                    16'(-$urandom_range(8000, 12000)),
                                    16'(34000 + $urandom_range(0, 5000))});
                        write_coeff(bsc_pkg::REG_PRESS_B,
                                    48'($urandom) | (48'($urandom) << 32));
                        write_coeff(bsc_pkg::REG_PRESS_C,
                                    48'($urandom) | (48'($urandom) << 32));
                    end
                endcase
            end
            if (i % 100 == 50) begin
                send_burst(20);
                i += 19;
            end else if ($urandom_range(0, 3) != 0) begin
                send_pair(20'(400000 + $urandom_range(0, 250000)),
                          20'(200000 + $urandom_range(0, 500000)));
            end else begin
                send_pair(20'($urandom), 20'($urandom));
            end
        end
        stim_done = 1'b1;
        drain();
        if (!failed && pending_results.size() == 0) begin
            $display("barometric_sensor_compensation_top_test: PASS");
        end else begin
            $display("barometric_sensor_compensation_top_test: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("barometric_sensor_compensation_top_test: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/bsc_pkg.sv
sv/bsc_mul64.sv
sv/bsc_div.sv
sv/barometric_sensor_compensation_top.sv
tb/sv/barometric_sensor_compensation_top_test.sv
